### hw/rtl/gls_pkg.sv
// ----------------------------------------------------------------------------
// gls_pkg: shared types and constants for the grid line-of-sight core
// Field widths, function codes and the walk setup carried to the step unit.
// ----------------------------------------------------------------------------
package gls_pkg;

  // Default side of the square grid, in cells.
  localparam int GRID_SIDE_DEF = 64;

  // Coordinate fields are fixed at six bits.
  localparam int COORD_W = 6;
  // The error term stays below twice the largest delta.
  localparam int ERR_W = COORD_W + 1;

  // Input and output word widths.
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;

  // Function codes carried in tuser.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Per-query setup of the line walk.
  typedef struct packed {
    logic               dx_zero;
    logic               dy_zero;
    logic               x_major;
    logic               sx_neg;
    logic               sy_neg;
    logic [COORD_W-1:0] minor;
    logic [COORD_W-1:0] major;
  } step_cfg_t;

endpackage

### hw/rtl/grid_line_of_sight_core.sv
// ----------------------------------------------------------------------------
// grid_line_of_sight_core: blocked-cell map with Bresenham line-of-sight query
// Stores one bit per grid cell and walks a line between two cells on request.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one word per item. tuser selects the function:
//   a write stores the blocked bit of one cell and produces no result, a
//   query walks the line from the origin cell to the goal cell and returns
//   one result word on the master channel with the visible bit.
//   A query passes from acceptance through a setup state, a walk that steps
//   from cell to cell through the step unit and the single map port, and a
//   finishing state that loads the output register; a blocked cell ends the
//   walk once its registered read data returns. Origin equal to goal answers
//   visible without a walk. s_tready is high again once the result is loaded.
//   After reset the map is cleared by a pass that writes one cell per cycle
//   over all GRID_SIDE * GRID_SIDE cells (4096 at the default), during which
//   s_tready is low.
//   The result sits in an output register. While the receiver stalls the
//   block still takes writes; a finished query waits in its last state until
//   the output register is free.
// ----------------------------------------------------------------------------
module grid_line_of_sight_core #(
  parameter int GRID_SIDE = gls_pkg::GRID_SIDE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Input channel.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata, lowest bit up: cell_x[5:0], cell_y[11:6], blocked[12],
  // goal_x[18:13], goal_y[24:19], zeros above.
  input  logic [gls_pkg::IN_DATA_W-1:0]    s_tdata,
  // s_tuser: func[0].
  input  logic [0:0]                       s_tuser,
  // Result channel.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata, lowest bit up: visible[0], zeros above.
  output logic [gls_pkg::OUT_DATA_W-1:0]   m_tdata
);

  localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = gls_pkg::COORD_W;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SETUP = 5'b00100,
    ST_WALK  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t                     state;
  state_t                     state_next;

  logic [ADDR_W-1:0]          clr_addr;
  logic [CW-1:0]              cx;
  logic [CW-1:0]              cy;
  logic [CW-1:0]              gx;
  logic [CW-1:0]              gy;
  logic [gls_pkg::ERR_W-1:0]  err;
  gls_pkg::step_cfg_t         cfg;
  logic                       pend;
  logic                       res;
  logic                       vis;

  // Fields of the incoming word.
  logic                       in_func;
  logic [CW-1:0]              in_x;
  logic [CW-1:0]              in_y;
  logic                       in_blocked;
  logic [CW-1:0]              in_gx;
  logic [CW-1:0]              in_gy;

  logic                       accept;
  logic                       out_free;

  // Step unit outputs.
  logic [CW-1:0]              nx;
  logic [CW-1:0]              ny;
  logic [gls_pkg::ERR_W-1:0]  nerr;

  // Setup arithmetic.
  logic [CW-1:0]              dx;
  logic [CW-1:0]              dy;
  gls_pkg::step_cfg_t         cfg_next;

  // Map port.
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_addr;
  logic                       ram_wdata;
  logic                       ram_rdata;

  logic                       blk_hit;
  logic                       at_goal;
  logic                       next_in_grid;

  function automatic logic in_grid(input logic [CW-1:0] x, input logic [CW-1:0] y);
    in_grid = (int'(x) < GRID_SIDE) && (int'(y) < GRID_SIDE);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [CW-1:0] x,
                                                  input logic [CW-1:0] y);
    cell_addr = ADDR_W'(int'(y) * GRID_SIDE + int'(x));
  endfunction

  assign in_x       = s_tdata[5:0];
  assign in_y       = s_tdata[11:6];
  assign in_blocked = s_tdata[12];
  assign in_gx      = s_tdata[18:13];
  assign in_gy      = s_tdata[24:19];
  assign in_func    = s_tuser[0];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {{(gls_pkg::OUT_DATA_W-1){1'b0}}, vis};

  gls_step u_step (
    .cfg  (cfg),
    .cx   (cx),
    .cy   (cy),
    .err  (err),
    .nx   (nx),
    .ny   (ny),
    .nerr (nerr)
  );

  gls_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Deltas and walk setup from the captured origin and goal.
  always_comb begin
    dx                = (gx >= cx) ? gx - cx : cx - gx;
    dy                = (gy >= cy) ? gy - cy : cy - gy;
    cfg_next.dx_zero  = (dx == '0);
    cfg_next.dy_zero  = (dy == '0);
    cfg_next.x_major  = dx > dy;
    cfg_next.sx_neg   = gx < cx;
    cfg_next.sy_neg   = gy < cy;
    cfg_next.minor    = (dx > dy) ? dy : dx;
    cfg_next.major    = (dx > dy) ? dx : dy;
  end

  // The previous walked cell was read last cycle; a set bit ends the walk
  // before the next step is taken.
  assign blk_hit      = pend && ram_rdata;
  assign at_goal      = (nx == gx) && (ny == gy);
  assign next_in_grid = in_grid(nx, ny);

  // Map port: the clearing pass, single-cell writes and walk reads share it.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = 1'b0;
    ram_addr  = cell_addr(nx, ny);
    case (state)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      ST_IDLE: begin
        ram_addr  = cell_addr(in_x, in_y);
        ram_wdata = in_blocked;
        ram_we    = accept && (in_func == gls_pkg::FUNC_WRITE) && in_grid(in_x, in_y);
      end
      default: begin
        ram_addr = cell_addr(nx, ny);
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && (in_func == gls_pkg::FUNC_QUERY)) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = (cfg_next.dx_zero && cfg_next.dy_zero) ? ST_DONE : ST_WALK;
      end
      ST_WALK: begin
        if (blk_hit || at_goal || !next_in_grid) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      // A finished query loads the output register when it is free.
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_SETUP: begin
          pend <= 1'b0;
        end
        ST_WALK: begin
          if (!blk_hit && !at_goal && next_in_grid) begin
            pend <= 1'b1;
          end
        end
        default: begin
          pend <= pend;
        end
      endcase
    end
  end

  // Walk payload registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cx <= in_x;
          cy <= in_y;
          gx <= in_gx;
          gy <= in_gy;
        end
      end
      ST_SETUP: begin
        cfg <= cfg_next;
        err <= '0;
        res <= 1'b1;
      end
      ST_WALK: begin
        if (blk_hit) begin
          res <= 1'b0;
        end else if (at_goal) begin
          res <= 1'b1;
        end else if (!next_in_grid) begin
          res <= 1'b0;
        end else begin
          cx  <= nx;
          cy  <= ny;
          err <= nerr;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          vis <= res;
        end
      end
      default: begin
        cx <= cx;
      end
    endcase
  end

  // The map is written only by the clearing pass or by an accepted write.
  a_map_write_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR) || (state == ST_IDLE && accept))
    else $error("map written outside clearing pass or write word");

  // The walk never rests on the goal cell.
  a_walk_off_goal: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> !((cx == gx) && (cy == gy)))
    else $error("walk position equals goal");

  // On a diagonal-type line the error term stays below the major delta.
  a_err_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && !cfg.dx_zero && !cfg.dy_zero) |-> (err < {1'b0, cfg.major}))
    else $error("error term out of range");

  // A result word appears only after the finishing state.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DONE))
    else $error("result offered without a finished query");

endmodule

### hw/rtl/gls_ram.sv
// ----------------------------------------------------------------------------
// gls_ram: generic single-port RAM
// One access per cycle at one address, read data registered (old word on a write).
// ----------------------------------------------------------------------------
module gls_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = gls_pkg::GRID_SIDE_DEF * gls_pkg::GRID_SIDE_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hw/rtl/gls_step.sv
// ----------------------------------------------------------------------------
// gls_step: one step of the line walk
// Moves the current cell one step along the line and updates the error term.
// ----------------------------------------------------------------------------
module gls_step (
  input  gls_pkg::step_cfg_t                 cfg,
  input  logic [gls_pkg::COORD_W-1:0]        cx,
  input  logic [gls_pkg::COORD_W-1:0]        cy,
  input  logic [gls_pkg::ERR_W-1:0]          err,
  output logic [gls_pkg::COORD_W-1:0]        nx,
  output logic [gls_pkg::COORD_W-1:0]        ny,
  output logic [gls_pkg::ERR_W-1:0]          nerr
);

  logic [gls_pkg::COORD_W-1:0] x_step;
  logic [gls_pkg::COORD_W-1:0] y_step;
  logic [gls_pkg::ERR_W-1:0]   err_sum;
  logic [gls_pkg::ERR_W-1:0]   major_ext;
  logic                        bump;

  // The walk stays inside the box spanned by origin and target, so the
  // unit steps never wrap.
  assign x_step    = cfg.sx_neg ? cx - gls_pkg::COORD_W'(1) : cx + gls_pkg::COORD_W'(1);
  assign y_step    = cfg.sy_neg ? cy - gls_pkg::COORD_W'(1) : cy + gls_pkg::COORD_W'(1);
  assign major_ext = {1'b0, cfg.major};
  assign err_sum   = err + {1'b0, cfg.minor};
  assign bump      = err_sum >= major_ext;

  always_comb begin
    nx   = cx;
    ny   = cy;
    nerr = err;
    if (cfg.dx_zero) begin
      ny = y_step;
    end else if (cfg.dy_zero) begin
      nx = x_step;
    end else begin
      if (cfg.x_major) begin
        nx = x_step;
        if (bump) begin
          ny = y_step;
        end
      end else begin
        ny = y_step;
        if (bump) begin
          nx = x_step;
        end
      end
      nerr = bump ? err_sum - major_ext : err_sum;
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for grid_line_of_sight_core
// Writes map cells and asks line-of-sight queries over the input stream. A
// local copy of the map and of the line walk predicts each visible bit, and
// every result word is checked against the oldest prediction in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int GRID_SIDE = gls_pkg::GRID_SIDE_DEF;
  localparam int NUM_RANDOM = 1330;
  localparam int HOLD_OFF_CYCLES = 400;
  // Longest query walk plus setup and output, with margin.
  localparam int DRAIN_CYCLES = 2 * GRID_SIDE + 16;

  // One input word, unpacked into its fields.
  typedef struct {
    logic                        func;
    logic [gls_pkg::COORD_W-1:0] cell_x;
    logic [gls_pkg::COORD_W-1:0] cell_y;
    logic                        blocked;
    logic [gls_pkg::COORD_W-1:0] goal_x;
    logic [gls_pkg::COORD_W-1:0] goal_y;
  } los_word_t;

  // Tracks the blocked map and the visible bits still owed by the block.
  class sight_tracker;
    bit          blocked_cells [GRID_SIDE*GRID_SIDE];
    bit          visible_due [$];
    int unsigned errors;

    function bit cell_blocks(int x, int y);
      if (x < 0 || y < 0 || x >= GRID_SIDE || y >= GRID_SIDE)
        return 1'b1;
      return blocked_cells[y*GRID_SIDE + x];
    endfunction

    // Bresenham walk; Y is the major axis when the deltas tie. The origin
    // and the target are never tested.
    function bit line_clear(int ox, int oy, int tx, int ty);
      int cx, cy, dx, dy, sx, sy, minor_d, major_d, err;
      bit x_major;
      cx = ox;
      cy = oy;
      dx = (tx >= ox) ? tx - ox : ox - tx;
      dy = (ty >= oy) ? ty - oy : oy - ty;
      sx = (tx >= ox) ? 1 : -1;
      sy = (ty >= oy) ? 1 : -1;
      x_major = dx > dy;
      minor_d = x_major ? dy : dx;
      major_d = x_major ? dx : dy;
      err = 0;
      if (dx == 0 && dy == 0)
        return 1'b1;
      for (int n = 0; n < 2 * GRID_SIDE; n++) begin
        if (dx == 0) begin
          cy += sy;
        end else if (dy == 0) begin
          cx += sx;
        end else begin
          if (x_major) cx += sx; else cy += sy;
          err += minor_d;
          if (err >= major_d) begin
            if (x_major) cy += sy; else cx += sx;
            err -= major_d;
          end
        end
        if (cx == tx && cy == ty)
          return 1'b1;
        if (cell_blocks(cx, cy))
          return 1'b0;
      end
      return 1'b0;
    endfunction

    function void take_word(los_word_t w);
      if (w.func == gls_pkg::FUNC_WRITE)
        blocked_cells[int'(w.cell_y)*GRID_SIDE + int'(w.cell_x)] = w.blocked;
      else
        visible_due.push_back(line_clear(w.cell_x, w.cell_y, w.goal_x, w.goal_y));
    endfunction

    function void check_visible(logic got);
      bit want;
      if (visible_due.size() == 0) begin
        $error("result word with no query outstanding: visible=%0b", got);
        errors++;
        return;
      end
      want = visible_due.pop_front();
      if (got !== want) begin
        $error("visible mismatch: expected %0b, actual %0b", want, got);
        errors++;
      end
    endfunction

    function void close_out();
      if (visible_due.size() != 0) begin
        $error("%0d query results never arrived", visible_due.size());
        errors++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [gls_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic [0:0]                     s_tuser = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [gls_pkg::OUT_DATA_W-1:0] m_tdata;

  sight_tracker tracker = new();
  bit           hold_off_req = 1'b0;
  int           burst_left = 0;

  grid_line_of_sight_core #(.GRID_SIDE(GRID_SIDE)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offers one word from a falling edge, holds it until the handshake, and
  // returns at the next falling edge with tvalid still high.
  task automatic send_word(los_word_t w);
    s_tvalid <= 1'b1;
    s_tuser  <= w.func;
    s_tdata  <= {7'b0, w.goal_y, w.goal_x, w.blocked, w.cell_y, w.cell_x};
    do @(posedge clk); while (!s_tready);
    tracker.take_word(w);
    @(negedge clk);
  endtask

  // Sender pacing: bursts of random length, most of them followed by a gap
  // with junk on the data lines.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 10);
        s_tvalid <= 1'b0;
        s_tdata  <= $urandom;
        s_tuser  <= 1'($urandom_range(0, 1));
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // Unused fields carry random bits, since the block must ignore them.
  task automatic put_cell(int x, int y, bit b);
    los_word_t w;
    w = '{gls_pkg::FUNC_WRITE, gls_pkg::COORD_W'(x), gls_pkg::COORD_W'(y), b,
          gls_pkg::COORD_W'($urandom_range(0, 63)),
          gls_pkg::COORD_W'($urandom_range(0, 63))};
    pace();
    send_word(w);
  endtask

  task automatic ask_sight(int x, int y, int gx, int gy);
    los_word_t w;
    w = '{gls_pkg::FUNC_QUERY, gls_pkg::COORD_W'(x), gls_pkg::COORD_W'(y),
          1'($urandom_range(0, 1)), gls_pkg::COORD_W'(gx), gls_pkg::COORD_W'(gy)};
    pace();
    send_word(w);
  endtask

  // Most coordinates fall in a 16-cell window so that queries meet the
  // cells written nearby; the rest span the whole grid.
  function automatic int pick_coord(int base);
    if ($urandom_range(0, 99) < 70)
      return base + $urandom_range(0, 15);
    return $urandom_range(0, GRID_SIDE - 1);
  endfunction

  // Receiver: a stall pattern that changes every so often, plus one long
  // hold-off on request so that the core backs up into its input.
  initial begin
    int mode, span, phase;
    phase = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk);
        phase++;
        if (hold_off_req) begin
          m_tready <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(negedge clk);
          hold_off_req = 1'b0;
        end
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= phase[2];
        endcase
      end
    end
  end

  // Every accepted result word is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      tracker.check_visible(m_tdata[0]);
  end

  // Main stimulus. The core clears its map after reset with s_tready low,
  // so the first word simply waits on the handshake.
  initial begin
    int win_x, win_y, x, y;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: grid extremes, both directions on each axis, diagonals
    // with the tie going to Y, blocked targets and origins, and a cell that
    // is blocked and then opened again.
    ask_sight(0, 0, 0, 0);
    put_cell(1, 0, 1'b1);
    ask_sight(0, 0, 63, 0);
    ask_sight(63, 0, 0, 0);
    ask_sight(0, 0, 1, 0);
    put_cell(63, 63, 1'b1);
    ask_sight(0, 0, 63, 63);
    put_cell(32, 32, 1'b1);
    ask_sight(0, 0, 63, 63);
    ask_sight(63, 0, 0, 63);
    put_cell(0, 40, 1'b1);
    ask_sight(0, 63, 0, 0);
    ask_sight(0, 0, 0, 63);
    put_cell(20, 13, 1'b1);
    ask_sight(5, 10, 60, 20);
    ask_sight(60, 20, 5, 10);
    ask_sight(10, 5, 20, 60);
    ask_sight(20, 60, 10, 5);
    put_cell(32, 32, 1'b0);
    ask_sight(63, 63, 0, 0);
    put_cell(10, 10, 1'b1);
    ask_sight(10, 10, 20, 12);
    ask_sight(63, 63, 63, 63);
    ask_sight(63, 62, 63, 63);

    // Random part. The long receiver hold-off starts right away while the
    // sender keeps offering words.
    hold_off_req = 1'b1;
    win_x = $urandom_range(0, GRID_SIDE - 16);
    win_y = $urandom_range(0, GRID_SIDE - 16);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 150 == 149) begin
        win_x = $urandom_range(0, GRID_SIDE - 16);
        win_y = $urandom_range(0, GRID_SIDE - 16);
      end
      x = pick_coord(win_x);
      y = pick_coord(win_y);
      if ($urandom_range(0, 99) < 45)
        put_cell(x, y, $urandom_range(0, 99) < 35);
      else if ($urandom_range(0, 9) == 0)
        ask_sight(x, y, x, y);
      else
        ask_sight(x, y, pick_coord(win_x), pick_coord(win_y));
    end
    s_tvalid <= 1'b0;

    while (tracker.visible_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    tracker.close_out();
    if (tracker.errors == 0)
      $display("PASS grid_line_of_sight_core");
    else
      $display("FAIL grid_line_of_sight_core");
    $finish;
  end

  // Run limit, far above the slowest correct run (map clear, long hold-off
  // and every query at full length behind a stalling receiver).
  initial begin
    #5_000_000;
    $display("FAIL grid_line_of_sight_core");
    $finish;
  end

endmodule
